// File: hdl/crtc_pkg.sv
// crtc_pkg: shared types and constants for the crt controller timing block
// used by every module under hdl; no dependencies of its own
`timescale 1ns / 1ps
`default_nettype none

package crtc_pkg;

   // item kinds
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } crtc_kind_type;

   // bus pages (high byte of the bus address)
   localparam logic [7:0] PAGE_SELECT = 8'hBC;
   localparam logic [7:0] PAGE_DATA   = 8'hBD;
   localparam logic [7:0] PAGE_READ   = 8'hBF;

   localparam int unsigned NUM_REGS = 16;

   // register indexes that drive the timing
   localparam int unsigned REG_H_TOTAL     = 0;
   localparam int unsigned REG_H_DISPLAYED = 1;
   localparam int unsigned REG_HSYNC_POS   = 2;
   localparam int unsigned REG_SYNC_WIDTH  = 3;
   localparam int unsigned REG_V_TOTAL     = 4;
   localparam int unsigned REG_V_DISPLAYED = 6;
   localparam int unsigned REG_VSYNC_POS   = 7;
   localparam int unsigned REG_MAX_RASTER  = 9;
   localparam int unsigned REG_START_HI    = 12;
   localparam int unsigned REG_START_LO    = 13;

   // register file values after reset
   localparam logic [7:0] REG_RESET [NUM_REGS] = '{
      8'd63, 8'd40, 8'd46, 8'd142, 8'd38, 8'd0, 8'd25, 8'd30,
      8'd0,  8'd7,  8'd0,  8'd0,   8'd48, 8'd0, 8'd0,  8'd0
   };

   // timing registers as seen after the current beat
   typedef struct packed {
      logic [7:0] h_total;
      logic [7:0] h_displayed;
      logic [7:0] hsync_pos;
      logic [7:0] sync_width;
      logic [7:0] v_total;
      logic [7:0] v_displayed;
      logic [7:0] vsync_pos;
      logic [7:0] max_raster;
      logic [7:0] start_hi;
      logic [7:0] start_lo;
   } crtc_regs_type;

   // counter state after the current beat
   typedef struct packed {
      logic [7:0]  column;
      logic [7:0]  raster;
      logic [7:0]  row;
      logic [15:0] start;
   } crtc_count_type;

   // video outputs for one result beat
   typedef struct packed {
      logic [15:0] video_address;
      logic        display_enable;
      logic        hsync;
      logic        vsync;
   } crtc_video_type;

endpackage

`default_nettype wire

// File: hdl/crtc_regs.sv
// crtc_regs: register select and sixteen-entry register file behind the bus
// depends on crtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module crtc_regs (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire logic [1:0]             kind,
   input  wire logic [7:0]             page,
   input  wire logic [7:0]             write_data,
   output crtc_pkg::crtc_regs_type     regs_next,
   output logic      [7:0]             read_data
);

   logic [7:0] reg_ff [crtc_pkg::NUM_REGS];
   logic [7:0] reg_in [crtc_pkg::NUM_REGS];
   logic [4:0] select_ff;
   logic [4:0] select_in;

   // bus decode: select write, data write, data read
   always_comb begin
      reg_in    = reg_ff;
      select_in = select_ff;
      read_data = 8'd0;
      if (kind == crtc_pkg::KIND_WRITE) begin
         if (page == crtc_pkg::PAGE_SELECT) begin
            select_in = write_data[4:0];
         end else if (page == crtc_pkg::PAGE_DATA && !select_ff[4]) begin
            reg_in[select_ff[3:0]] = write_data;
         end
      end else if (kind == crtc_pkg::KIND_READ) begin
         if (page == crtc_pkg::PAGE_READ && !select_ff[4]) begin
            read_data = reg_ff[select_ff[3:0]];
         end
      end
   end

   // commit on each beat
   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff <= 5'd0;
         for (int i = 0; i < crtc_pkg::NUM_REGS; i++) begin
            reg_ff[i] <= crtc_pkg::REG_RESET[i];
         end
      end else if (fire) begin
         select_ff <= select_in;
         reg_ff    <= reg_in;
      end
   end

   // timing view of the file after this beat
   always_comb begin
      regs_next.h_total     = reg_in[crtc_pkg::REG_H_TOTAL];
      regs_next.h_displayed = reg_in[crtc_pkg::REG_H_DISPLAYED];
      regs_next.hsync_pos   = reg_in[crtc_pkg::REG_HSYNC_POS];
      regs_next.sync_width  = reg_in[crtc_pkg::REG_SYNC_WIDTH];
      regs_next.v_total     = reg_in[crtc_pkg::REG_V_TOTAL];
      regs_next.v_displayed = reg_in[crtc_pkg::REG_V_DISPLAYED];
      regs_next.vsync_pos   = reg_in[crtc_pkg::REG_VSYNC_POS];
      regs_next.max_raster  = reg_in[crtc_pkg::REG_MAX_RASTER];
      regs_next.start_hi    = reg_in[crtc_pkg::REG_START_HI];
      regs_next.start_lo    = reg_in[crtc_pkg::REG_START_LO];
   end

   // a read of an out-of-range register gives zero
   a_read_range: assert property (@(posedge clock) disable iff (reset)
      select_ff[4] |-> read_data == 8'd0)
      else $error("read of unused register returned data");

endmodule

`default_nettype wire

// File: hdl/crtc_timing.sv
// crtc_timing: tick prescaler, column/raster/row counters and start address
// depends on crtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module crtc_timing (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire logic [1:0]             kind,
   input  wire crtc_pkg::crtc_regs_type regs,
   output crtc_pkg::crtc_count_type    count_next
);

   crtc_pkg::crtc_count_type count_ff;
   crtc_pkg::crtc_count_type count_in;
   logic [1:0]               presc_ff;
   logic [1:0]               presc_in;
   logic                     tick;

   assign tick = (kind == crtc_pkg::KIND_TICK);

   // counter advance on every fourth tick
   always_comb begin
      count_in = count_ff;
      presc_in = presc_ff;
      if (tick) begin
         presc_in = presc_ff + 2'd1;
         if (presc_ff == 2'd3) begin
            count_in.column = count_ff.column + 8'd1;
            if (count_in.column > regs.h_total) begin
               count_in.column = 8'd0;
               count_in.raster = count_ff.raster + 8'd1;
            end
            if (count_in.raster > regs.max_raster) begin
               count_in.raster = 8'd0;
               count_in.row    = count_ff.row + 8'd1;
            end
            if (count_in.row > regs.v_total) begin
               count_in.row = 8'd0;
            end
            if (count_in.row == 8'd0 && count_in.column == 8'd0) begin
               count_in.start = {regs.start_hi, regs.start_lo};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         presc_ff <= 2'd0;
      end else if (fire) begin
         count_ff <= count_in;
         presc_ff <= presc_in;
      end
   end

   assign count_next = count_in;

   // prescaler steps once per committed tick
   a_presc_step: assert property (@(posedge clock) disable iff (reset)
      fire && tick |=> presc_ff == $past(presc_ff) + 2'd1)
      else $error("prescaler did not step on a tick");

   // counters move only on the fourth tick
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !(fire && tick && presc_ff == 2'd3) |=> $stable(count_ff))
      else $error("counters moved outside a prescaled tick");

endmodule

`default_nettype wire

// File: hdl/crtc_video.sv
// crtc_video: video address, display enable and sync decode from counters
// depends on crtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module crtc_video (
   input  wire crtc_pkg::crtc_regs_type  regs,
   input  wire crtc_pkg::crtc_count_type count,
   output crtc_pkg::crtc_video_type    video
);

   logic [15:0]        line_offset;
   logic [15:0]        cur;
   logic [8:0]         hsync_end;
   logic [7:0]         row_diff;
   logic [8:0]         raster_height;
   logic signed [16:0] vs_product;

   // linear character address
   assign line_offset = {8'd0, regs.h_displayed} * {8'd0, count.row};
   assign cur         = count.start + line_offset + {8'd0, count.column};

   // sync windows
   assign hsync_end     = {1'b0, regs.hsync_pos} + {5'd0, regs.sync_width[3:0]};
   assign row_diff      = count.row - regs.vsync_pos;
   assign raster_height = {1'b0, regs.max_raster + 8'd1};
   assign vs_product    = $signed({8'd0, raster_height})
                          * $signed({{9{row_diff[7]}}, row_diff});

   always_comb begin
      video.video_address  = {cur[13:12], count.raster[2:0], cur[9:0], 1'b0};
      video.display_enable = (count.column < regs.h_displayed)
                             && (count.row < regs.v_displayed);
      video.hsync          = (count.column >= regs.hsync_pos)
                             && ({1'b0, count.column} < hsync_end);
      video.vsync          = !vs_product[16] && (vs_product <= 17'sd16);
   end

endmodule

`default_nettype wire

// File: hdl/crt_controller_timing.sv
// crt_controller_timing: top level of the crt controller timing block
// path: a request beat is held in the input register, then its result in the result register
// throughput: one beat per cycle while rsp_ready is not holding the result, ticks and bus accesses alike
// the input register and result register keep both sides running under stalls
// reset: synchronous, restores the register file defaults and clears counters
// depends on crtc_pkg, crtc_regs, crtc_timing, crtc_video
`timescale 1ns / 1ps
`default_nettype none

module crt_controller_timing (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [15:0] req_bus_address,
   input  wire logic [7:0]  req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_video_address,
   output logic             rsp_display_enable,
   output logic             rsp_hsync,
   output logic             rsp_vsync,
   output logic [7:0]       rsp_read_data
);

   logic                      in_valid_ff;
   logic [1:0]                in_kind_ff;
   logic [7:0]                in_page_ff;
   logic [7:0]                in_data_ff;
   logic                      core_fire;
   logic                      rsp_valid_ff;
   crtc_pkg::crtc_video_type  rsp_video_ff;
   logic [7:0]                rsp_read_data_ff;
   crtc_pkg::crtc_regs_type   regs_next;
   crtc_pkg::crtc_count_type  count_next;
   crtc_pkg::crtc_video_type  video;
   logic [7:0]                read_data;

   // handshake: the held beat moves on when the result register is free
   assign core_fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || core_fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff <= req_kind;
         in_page_ff <= req_bus_address[15:8];
         in_data_ff <= req_write_data;
      end
   end

   crtc_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .fire       (core_fire),
      .kind       (in_kind_ff),
      .page       (in_page_ff),
      .write_data (in_data_ff),
      .regs_next  (regs_next),
      .read_data  (read_data)
   );

   crtc_timing u_timing (
      .clock      (clock),
      .reset      (reset),
      .fire       (core_fire),
      .kind       (in_kind_ff),
      .regs       (regs_next),
      .count_next (count_next)
   );

   crtc_video u_video (
      .regs  (regs_next),
      .count (count_next),
      .video (video)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_fire) begin
         rsp_video_ff     <= video;
         rsp_read_data_ff <= read_data;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_video_address  = rsp_video_ff.video_address;
   assign rsp_display_enable = rsp_video_ff.display_enable;
   assign rsp_hsync          = rsp_video_ff.hsync;
   assign rsp_vsync          = rsp_video_ff.vsync;
   assign rsp_read_data      = rsp_read_data_ff;

   // only read beats carry read data
   a_read_only: assert property (@(posedge clock) disable iff (reset)
      core_fire && in_kind_ff != crtc_pkg::KIND_READ |=> rsp_read_data_ff == 8'd0)
      else $error("read data on a non-read beat");

   // a held beat is never dropped
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !core_fire |=> in_valid_ff)
      else $error("input beat lost");

endmodule

`default_nettype wire
